// ----- rtl/ilir_pkg.sv -----
package ilir_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Cell index, entry count and the width used to compare positions.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_UPDATE = 3'd3,
        OP_FIND   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                  en;
        op_t                   op;
        logic [4:0]            pos;
        logic [DATA_WIDTH-1:0] val;
        logic [CNT_W-1:0]      count;
    } cell_cmd_t;

    // Input value truncated to the stored width.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Stored word sign-extended, then cut to the 32-bit result field.
    function automatic logic [31:0] to_output(input logic signed [DATA_WIDTH-1:0] d);
        logic signed [63:0] w;
        w = 64'(d);
        return w[31:0];
    endfunction

endpackage

// ----- rtl/ilir_cell.sv -----
module ilir_cell import ilir_pkg::*; (
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [IDX_W-1:0]      idx,
    input  logic [DATA_WIDTH-1:0] lower_data,
    input  logic [DATA_WIDTH-1:0] upper_data,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  match,
    output logic [DATA_WIDTH-1:0] sel_data
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic [CMP_W-1:0]      my_idx;
    logic [CMP_W-1:0]      my_pos;
    logic [CMP_W-1:0]      my_cnt;

    assign my_idx = CMP_W'(idx);
    assign my_pos = CMP_W'(cmd.pos);
    assign my_cnt = CMP_W'(cmd.count);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.en) begin
            case (cmd.op)
                OP_INSERT: begin
                    if (my_idx == my_pos) begin
                        entry_next = cmd.val;
                    end else if (my_idx > my_pos) begin
                        entry_next = lower_data;
                    end
                end
                OP_REMOVE: begin
                    if (my_idx >= my_pos) begin
                        entry_next = upper_data;
                    end
                end
                OP_UPDATE: begin
                    if (my_idx == my_pos) begin
                        entry_next = cmd.val;
                    end
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign match    = (my_idx < my_cnt) && (entry_reg == cmd.val);
    assign sel_data = (my_idx == my_pos) ? entry_reg : '0;

endmodule

// ----- rtl/indexed_list_insert_remove.sv -----
// A request accepted on s_tvalid/s_tready is registered first in the s1_* stage, then in the
// m_* output stage that drives m_tvalid; a low m_tready can hold it in either stage.
// Throughput: one request per cycle while m_tready stays high; every cell shifts,
// writes and compares in the same cycle, so the whole list moves at once.
// Reset (aresetn low at a clock edge) empties the list and both pipeline stages;
// the stored words themselves are not cleared and are only read after being written.
module indexed_list_insert_remove import ilir_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [7:3] position, [39:8] value
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] read_data, [37:34] found_position, [42:38] entry_count
    output logic [47:0] m_tdata
);

    op_t                   in_op;
    logic [4:0]            in_pos;
    logic [DATA_WIDTH-1:0] in_val;
    logic                  accept;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      cnt_cmp;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_pre;
    logic                  modify;
    cell_cmd_t             cmd;

    logic [DATA_WIDTH-1:0] cell_entry [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_sel   [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;
    logic [DATA_WIDTH-1:0] get_word;

    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    status_t               s1_status_reg;
    logic [CNT_W-1:0]      s1_count_reg;
    logic [31:0]           s1_rdata_reg;
    logic [31:0]           s1_fval_reg;
    logic [CAPACITY-1:0]   s1_hit_reg;
    logic                  s1_adv;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [31:0]           m_data_reg;
    logic [3:0]            m_fpos_reg;
    logic [4:0]            m_count_reg;

    status_t               out_status;
    logic [31:0]           out_data;
    logic [IDX_W-1:0]      first_idx;

    assign in_op   = op_t'(s_tdata[2:0]);
    assign in_pos  = s_tdata[7:3];
    assign in_val  = to_store(s_tdata[39:8]);
    assign accept  = s_tvalid && s_tready;
    assign pos_cmp = CMP_W'(in_pos);
    assign cnt_cmp = CMP_W'(count_reg);

    // Status and new count are decided before the request reaches the cells.
    always_comb begin
        status_pre = ST_OK;
        modify     = 1'b0;
        count_next = count_reg;
        case (in_op)
            OP_INSERT: begin
                if (pos_cmp > cnt_cmp) begin
                    status_pre = ST_BAD_POS;
                end else if (cnt_cmp >= CMP_W'(CAPACITY)) begin
                    status_pre = ST_FULL;
                end else begin
                    modify     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos_cmp >= cnt_cmp) begin
                    status_pre = ST_BAD_POS;
                end else begin
                    modify     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_GET: begin
                if (pos_cmp >= cnt_cmp) begin
                    status_pre = ST_BAD_POS;
                end
            end
            OP_UPDATE: begin
                if (pos_cmp >= cnt_cmp) begin
                    status_pre = ST_BAD_POS;
                end else begin
                    modify = 1'b1;
                end
            end
            default: begin
                status_pre = ST_OK;
            end
        endcase
    end

    assign cmd.en    = accept && modify;
    assign cmd.op    = in_op;
    assign cmd.pos   = in_pos;
    assign cmd.val   = in_val;
    assign cmd.count = count_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;
        if (i == 0) begin : g_first
            assign lower = '0;
        end else begin : g_lower
            assign lower = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper = cell_entry[i];
        end else begin : g_upper
            assign upper = cell_entry[i+1];
        end
        ilir_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .lower_data (lower),
            .upper_data (upper),
            .entry      (cell_entry[i]),
            .match      (cell_match[i]),
            .sel_data   (cell_sel[i])
        );
    end

    always_comb begin
        get_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            get_word = get_word | cell_sel[k];
        end
    end

    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg     <= in_op;
            s1_status_reg <= status_pre;
            s1_count_reg  <= count_next;
            s1_rdata_reg  <= to_output(get_word);
            s1_fval_reg   <= to_output(in_val);
            s1_hit_reg    <= cell_match;
        end
    end

    // The lowest matching cell wins.
    always_comb begin
        first_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (s1_hit_reg[k]) begin
                first_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        out_status = s1_status_reg;
        out_data   = '0;
        case (s1_op_reg)
            OP_GET: begin
                if (s1_status_reg == ST_OK) begin
                    out_data = s1_rdata_reg;
                end
            end
            OP_FIND: begin
                if (|s1_hit_reg) begin
                    out_data = s1_fval_reg;
                end else begin
                    out_status = ST_NOT_FOUND;
                end
            end
            default: begin
                out_data = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_status_reg <= out_status;
            m_data_reg   <= out_data;
            m_fpos_reg   <= (s1_op_reg == OP_FIND && (|s1_hit_reg)) ? 4'(first_idx) : 4'd0;
            m_count_reg  <= 5'(s1_count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_fpos_reg, m_data_reg, m_status_reg};

endmodule

// ----- rtl/ilir_checker.sv -----
module ilir_checker import ilir_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A stalled result must hold its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[42:38] <= 5'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[42:38] == 5'(CAPACITY))
        else $error("list full reported while not full");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_NOT_FOUND |-> m_tdata[37:2] == '0)
        else $error("failed search carries data");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);
